// ===== hw/rtl/sbr_pkg.sv =====
// Package for the subset bitmap rank core.
// Holds word widths, multiplier operand selects and the controller/datapath structs.
// No dependencies.
package sbr_pkg;

	localparam int DATA_W = 64;
	localparam int CNT_W  = 7;
	localparam int CYC_W  = $clog2(DATA_W);

	localparam logic MSEL_A = 1'b0;
	localparam logic MSEL_B = 1'b1;

	typedef struct packed {
		logic load;
		logic step_zero;
		logic bin_one;
		logic step_one;
		logic mul;
		logic msel;
		logic div_start;
		logic fin;
		logic out_load;
	} sbr_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic bit0;
		logic col_first;
		logic row_eq_col;
		logic div_busy;
		logic div_done;
		logic out_full;
	} sbr_stat_t;

endpackage

// ===== hw/rtl/sbr_div.sv =====
// Bit-serial restoring divider: 64-bit dividend by a 7-bit divisor, one quotient bit a cycle.
// Depends on sbr_pkg.
module sbr_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [sbr_pkg::DATA_W-1:0] dividend,
	input  logic [sbr_pkg::CNT_W-1:0]  divisor,
	output logic                       busy,
	output logic                       done,
	output logic [sbr_pkg::DATA_W-1:0] quotient
);

	localparam logic [sbr_pkg::CYC_W-1:0] LAST = sbr_pkg::CYC_W'(sbr_pkg::DATA_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [sbr_pkg::CYC_W-1:0]  cnt_q;
	logic [sbr_pkg::DATA_W-1:0] dq_q;
	logic [sbr_pkg::CNT_W-1:0]  rem_q;
	logic [sbr_pkg::CNT_W-1:0]  dvs_q;
	logic [sbr_pkg::CNT_W:0]    sh;
	logic [sbr_pkg::CNT_W:0]    diff;
	logic                       ge;
	logic [sbr_pkg::CNT_W-1:0]  rem_d;

	assign sh    = {rem_q, dq_q[sbr_pkg::DATA_W-1]};
	assign ge    = sh >= {1'b0, dvs_q};
	assign diff  = sh - {1'b0, dvs_q};
	assign rem_d = ge ? diff[sbr_pkg::CNT_W-1:0] : sh[sbr_pkg::CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q  <= {dq_q[sbr_pkg::DATA_W-2:0], ge};
			rem_q <= rem_d;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = dq_q;

endmodule

// ===== hw/rtl/sbr_datapath.sv =====
// Datapath of the rank core: triangle position, binomial, modified term, sum and result register.
// Depends on sbr_pkg and sbr_div.
module sbr_datapath #(
	parameter int WORD_BITS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sbr_pkg::sbr_cmd_t          cmd,
	output sbr_pkg::sbr_stat_t         stat,
	input  logic [sbr_pkg::DATA_W-1:0] subset_bits,
	input  logic [sbr_pkg::CNT_W-1:0]  bit_count,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sbr_pkg::DATA_W-1:0] rank
);

	logic [WORD_BITS-1:0]       bits_q;
	logic [sbr_pkg::CNT_W-1:0]  count_q;
	logic [sbr_pkg::CNT_W-1:0]  rp_q;
	logic [sbr_pkg::CNT_W-1:0]  cp_q;
	logic [sbr_pkg::DATA_W-1:0] binom_q;
	logic [sbr_pkg::DATA_W-1:0] mod_q;
	logic [sbr_pkg::DATA_W-1:0] sum_q;
	logic [sbr_pkg::DATA_W-1:0] prod_q;
	logic [sbr_pkg::CNT_W-1:0]  dvs_q;
	logic [sbr_pkg::DATA_W-1:0] rank_q;
	logic                       out_valid_q;
	logic [sbr_pkg::CNT_W-1:0]  mul_m;
	logic [sbr_pkg::CNT_W-1:0]  mul_d;
	logic [sbr_pkg::DATA_W-1:0] mult;
	logic                       div_busy;
	logic                       div_done;
	logic [sbr_pkg::DATA_W-1:0] quotient;

	assign mul_m = (cmd.msel == sbr_pkg::MSEL_A) ? rp_q - sbr_pkg::CNT_W'(1) : rp_q - cp_q;
	assign mul_d = (cmd.msel == sbr_pkg::MSEL_A) ? rp_q - cp_q : cp_q;
	assign mult  = binom_q * sbr_pkg::DATA_W'(mul_m);

	sbr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (dvs_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bits_q  <= subset_bits[WORD_BITS-1:0];
			count_q <= bit_count;
			rp_q    <= '0;
			cp_q    <= '0;
			binom_q <= '0;
			mod_q   <= '0;
			sum_q   <= '0;
		end else begin
			if (cmd.step_zero) begin
				rp_q  <= rp_q + 1'b1;
				mod_q <= (mod_q << 1) - binom_q;
			end
			if (cmd.step_one) begin
				rp_q  <= rp_q + 1'b1;
				cp_q  <= cp_q + 1'b1;
				mod_q <= (mod_q << 1) + binom_q;
			end
			if (cmd.bin_one) begin
				binom_q <= sbr_pkg::DATA_W'(1);
			end else if (div_done) begin
				binom_q <= quotient;
			end
			if (cmd.fin) begin
				sum_q   <= sum_q + mod_q;
				bits_q  <= bits_q >> 1;
				count_q <= count_q - 1'b1;
			end
		end
		if (cmd.mul) begin
			prod_q <= mult;
			dvs_q  <= mul_d;
		end
		if (cmd.out_load) begin
			rank_q <= sum_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.count_zero = (count_q == '0);
	assign stat.bit0       = bits_q[0];
	assign stat.col_first  = (cp_q == '0);
	assign stat.row_eq_col = (rp_q == cp_q);
	assign stat.div_busy   = div_busy;
	assign stat.div_done   = div_done;
	assign stat.out_full   = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign rank      = rank_q;

endmodule

// ===== hw/rtl/sbr_ctrl.sv =====
// Controller of the rank core: sequences bit steps, multiplies and divides.
// Depends on sbr_pkg.
module sbr_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  sbr_pkg::sbr_stat_t stat,
	output sbr_pkg::sbr_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CHECK  = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_DSTART = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_ONE    = 3'd5;
	localparam logic [2:0] S_FIN    = 3'd6;
	localparam logic [2:0] S_OUT    = 3'd7;

	localparam logic RET_FIN = 1'b0;
	localparam logic RET_ONE = 1'b1;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       msel_q;
	logic       msel_d;
	logic       ret_q;
	logic       ret_d;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		msel_d   = msel_q;
		ret_d    = ret_q;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (stat.count_zero) begin
					state_d = S_OUT;
				end else if (!stat.bit0) begin
					cmd.step_zero = 1'b1;
					msel_d        = sbr_pkg::MSEL_A;
					ret_d         = RET_FIN;
					state_d       = S_MUL;
				end else if (stat.col_first) begin
					cmd.bin_one = 1'b1;
					state_d     = S_ONE;
				end else begin
					msel_d  = sbr_pkg::MSEL_B;
					ret_d   = RET_ONE;
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul  = 1'b1;
				cmd.msel = msel_q;
				state_d  = S_DSTART;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV;
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = (ret_q == RET_ONE) ? S_ONE : S_FIN;
				end
			end
			S_ONE: begin
				cmd.step_one = 1'b1;
				if (stat.row_eq_col) begin
					cmd.bin_one = 1'b1;
					state_d     = S_FIN;
				end else begin
					msel_d  = sbr_pkg::MSEL_A;
					ret_d   = RET_FIN;
					state_d = S_MUL;
				end
			end
			S_FIN: begin
				cmd.fin = 1'b1;
				state_d = S_CHECK;
			end
			S_OUT: begin
				if (!stat.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			msel_q  <= sbr_pkg::MSEL_A;
			ret_q   <= RET_FIN;
		end else begin
			state_q <= state_d;
			msel_q  <= msel_d;
			ret_q   <= ret_d;
		end
	end

endmodule

// ===== hw/rtl/subset_bitmap_rank_core.sv =====
// Top level of the subset bitmap rank core: controller, datapath and port packing.
// Depends on sbr_pkg, sbr_ctrl and sbr_datapath (which holds sbr_div).
//
// Usage:
//   Slave channel s_*: one transfer carries a subset bitmap and a bit count n.
//   Master channel m_*: one transfer per input carries the rank of that subset.
//   The core scans the low n bitmap bits, bit 0 first, walking Pascal's
//   triangle; bits at or above WORD_BITS count as zero, counts above 64 scan
//   zero bits past the bitmap. All arithmetic wraps modulo 2^64.
// Timing:
//   One item at a time; s_tready is high only while the core is idle. A set
//   bit needs no divide if it is the first set bit at bit 0, one if the first
//   set bit comes later or all bits so far are set, and two otherwise.
//   The bit-serial divider sets the pace: one quotient bit per cycle and a
//   one-cycle done pulse per divide, one divide per clear bit, up to two per set bit.
//   m_tvalid rises once the last bit step has passed the check and output
//   states, and s_tready rises in the same cycle as m_tvalid.
// Reset and stalls:
//   arst_n clears the controller, the divider state and m_tvalid; no clearing pass.
//   The result sits in an output register: s_tready returns as soon as it is
//   loaded, and a stalled m_tready only holds the core once a second result
//   is ready while the first is still waiting.
module subset_bitmap_rank_core #(
	parameter int WORD_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // subset_bits[63:0], bit_count[70:64], zero pad [71]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // rank[63:0]
);

	sbr_pkg::sbr_cmd_t  cmd;
	sbr_pkg::sbr_stat_t stat;

	logic [sbr_pkg::DATA_W-1:0] subset_bits;
	logic [sbr_pkg::CNT_W-1:0]  bit_count;
	logic [sbr_pkg::DATA_W-1:0] rank;

	assign subset_bits = s_tdata[63:0];
	assign bit_count   = s_tdata[70:64];

	sbr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sbr_datapath #(
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.subset_bits (subset_bits),
		.bit_count   (bit_count),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.rank        (rank)
	);

	assign m_tdata = rank;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !stat.div_busy)
		else $error("divider restarted while busy");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_tvalid && !m_tready))
		else $error("result register overwritten while stalled");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !stat.div_busy && !cmd.fin)
		else $error("new item loaded during a bit step");

endmodule
